/* rtl/dtm_pkg.sv */
// dtm_pkg: shared constants, codes and types of the table-driven dfa matcher
`default_nettype none

package dtm_pkg;

	localparam int STATE_COUNT   = 256;
	localparam int ALPHABET_SIZE = 128;
	localparam int STATE_BITS    = 8;
	localparam int CHAR_BITS     = 7;
	localparam int LEN_BITS      = 16;
	localparam int TBL_DEPTH     = STATE_COUNT * ALPHABET_SIZE;
	localparam int TBL_AW        = STATE_BITS + CHAR_BITS;
	localparam int TBL_W         = STATE_BITS + 1;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = 2;
	localparam int FIFO_CW       = 3;

	typedef enum logic [1:0] {
		MODE_WR_TRANS = 2'd0,
		MODE_WR_ACC   = 2'd1,
		MODE_CHAR     = 2'd2,
		MODE_END      = 2'd3
	} dtm_mode_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic [STATE_BITS-1:0] state_index;
		logic [CHAR_BITS-1:0]  character;
		logic [STATE_BITS-1:0] next_state;
		logic                  entry_valid;
		logic                  accept_flag;
	} dtm_item_t;

	typedef struct packed {
		logic vld;
		logic is_char;
		logic is_end;
		logic ent_valid;
		logic acc;
	} dtm_step_t;

	typedef struct packed {
		logic                accepted;
		logic [LEN_BITS-1:0] match_length;
	} dtm_res_t;

endpackage

`default_nettype wire

/* rtl/dtm_in_if.sv */
// dtm_in_if: input channel of the matcher, valid/ready with item fields
`default_nettype none

interface dtm_in_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      mode;
	logic [dtm_pkg::STATE_BITS-1:0]  state_index;
	logic [dtm_pkg::CHAR_BITS-1:0]   character;
	logic [dtm_pkg::STATE_BITS-1:0]  next_state;
	logic                            entry_valid;
	logic                            accept_flag;

	modport source (
		output valid, mode, state_index, character, next_state, entry_valid, accept_flag,
		input  ready
	);
	modport sink (
		input  valid, mode, state_index, character, next_state, entry_valid, accept_flag,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/dtm_out_if.sv */
// dtm_out_if: result channel of the matcher, valid/ready with result fields
`default_nettype none

interface dtm_out_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [dtm_pkg::LEN_BITS-1:0]  match_length;

	modport source (
		output valid, accepted, match_length,
		input  ready
	);
	modport sink (
		input  valid, accepted, match_length,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/dtm_ram.sv */
// dtm_ram: generic simple dual-port ram, one write and one registered read port
`default_nettype none

module dtm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/dtm_walk.sv */
// dtm_walk: table and accept-flag memories, clearing sweep and state walk
`default_nettype none

module dtm_walk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire dtm_pkg::dtm_item_t item,
	output logic                    busy,
	output logic                    vld_s1,
	output dtm_pkg::dtm_step_t      step_s2
);

	logic                            clr_busy_q;
	logic [dtm_pkg::TBL_AW-1:0]      clr_addr_q;
	logic [dtm_pkg::STATE_BITS-1:0]  state_q;
	logic [dtm_pkg::STATE_BITS-1:0]  fwd_state;
	logic                            char_s1;
	logic                            end_s1;
	logic                            vld_s2;
	logic                            char_s2;
	logic                            end_s2;
	logic                            ent_valid_s2;

	logic                            tbl_we;
	logic [dtm_pkg::TBL_AW-1:0]      tbl_waddr;
	logic [dtm_pkg::TBL_W-1:0]       tbl_wdata;
	logic [dtm_pkg::TBL_AW-1:0]      tbl_raddr;
	logic [dtm_pkg::TBL_W-1:0]       tbl_rdata;
	logic                            acc_we;
	logic [dtm_pkg::STATE_BITS-1:0]  acc_waddr;
	logic                            acc_wdata;
	logic [dtm_pkg::STATE_BITS-1:0]  acc_raddr;
	logic                            acc_rdata;
	logic                            is_char;
	logic                            is_end;

	assign is_char = fire && (item.mode == dtm_pkg::MODE_CHAR);
	assign is_end  = fire && (item.mode == dtm_pkg::MODE_END);

	// clearing sweep over the whole table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + dtm_pkg::TBL_AW'(1);
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign busy = clr_busy_q;

	// state forwarded from the beat in s1
	always_comb begin
		if (end_s1) begin
			fwd_state = '0;
		end else if (char_s1 && tbl_rdata[dtm_pkg::TBL_W-1]) begin
			fwd_state = tbl_rdata[dtm_pkg::STATE_BITS-1:0];
		end else begin
			fwd_state = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			state_q <= fwd_state;
		end
	end

	always_comb begin
		tbl_we    = clr_busy_q || (fire && (item.mode == dtm_pkg::MODE_WR_TRANS));
		tbl_waddr = clr_busy_q ? clr_addr_q : {item.state_index, item.character};
		tbl_wdata = (!clr_busy_q && item.entry_valid) ? {1'b1, item.next_state} : '0;
		tbl_raddr = {fwd_state, item.character};
		acc_we    = clr_busy_q || (fire && (item.mode == dtm_pkg::MODE_WR_ACC));
		acc_waddr = clr_busy_q ? clr_addr_q[dtm_pkg::STATE_BITS-1:0] : item.state_index;
		acc_wdata = !clr_busy_q && item.accept_flag;
		acc_raddr = char_s1 ? tbl_rdata[dtm_pkg::STATE_BITS-1:0] : state_q;
	end

	dtm_ram #(
		.WIDTH(dtm_pkg::TBL_W),
		.DEPTH(dtm_pkg::TBL_DEPTH)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	dtm_ram #(
		.WIDTH(1),
		.DEPTH(dtm_pkg::STATE_COUNT)
	) u_acc (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			char_s1 <= 1'b0;
			end_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			char_s2 <= 1'b0;
			end_s2  <= 1'b0;
		end else begin
			vld_s1  <= fire;
			char_s1 <= is_char;
			end_s1  <= is_end;
			vld_s2  <= vld_s1;
			char_s2 <= char_s1;
			end_s2  <= end_s1;
		end
	end

	always_ff @(posedge clk) begin
		ent_valid_s2 <= tbl_rdata[dtm_pkg::TBL_W-1];
	end

	assign step_s2 = '{
		vld:       vld_s2,
		is_char:   char_s2,
		is_end:    end_s2,
		ent_valid: ent_valid_s2,
		acc:       acc_rdata
	};

endmodule

`default_nettype wire

/* rtl/dtm_verdict.sv */
// dtm_verdict: run bookkeeping, length count and result decision
`default_nettype none

module dtm_verdict (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               match_mode,
	input  wire dtm_pkg::dtm_step_t step,
	output logic                    res_valid,
	output dtm_pkg::dtm_res_t       res
);

	logic                          verdict_q;
	logic                          reached_q;
	logic [dtm_pkg::LEN_BITS-1:0]  len_q;
	logic [dtm_pkg::LEN_BITS-1:0]  len_inc;
	logic                          verdict_d;
	logic                          reached_d;
	logic [dtm_pkg::LEN_BITS-1:0]  len_d;

	assign len_inc = (&len_q) ? len_q : len_q + dtm_pkg::LEN_BITS'(1);

	always_comb begin
		verdict_d = verdict_q;
		reached_d = reached_q;
		len_d     = len_q;
		res_valid = 1'b0;
		res       = '{accepted: 1'b0, match_length: '0};
		if (step.is_end) begin
			if (!verdict_q) begin
				res_valid = 1'b1;
				if (!match_mode) begin
					res.accepted = step.acc;
				end else if (reached_q) begin
					res.accepted     = 1'b1;
					res.match_length = len_q;
				end
			end
			verdict_d = 1'b0;
			reached_d = 1'b0;
			len_d     = '0;
		end else if (step.is_char && !verdict_q) begin
			if (!step.ent_valid) begin
				verdict_d = 1'b1;
				res_valid = 1'b1;
			end else begin
				len_d = len_inc;
				if (match_mode) begin
					if (step.acc) begin
						reached_d = 1'b1;
					end else if (reached_q) begin
						// length stops before the leaving character
						verdict_d        = 1'b1;
						res_valid        = 1'b1;
						res.accepted     = 1'b1;
						res.match_length = len_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q <= 1'b0;
			reached_q <= 1'b0;
			len_q     <= '0;
		end else if (step.vld) begin
			verdict_q <= verdict_d;
			reached_q <= reached_d;
			len_q     <= len_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/dtm_out_fifo.sv */
// dtm_out_fifo: small result queue between the verdict stage and the output
`default_nettype none

module dtm_out_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire dtm_pkg::dtm_res_t            push_data,
	input  wire logic                         pop,
	output logic                              not_empty,
	output dtm_pkg::dtm_res_t                 head,
	output logic [dtm_pkg::FIFO_CW-1:0]       count
);

	dtm_pkg::dtm_res_t                 slot_q [dtm_pkg::FIFO_DEPTH];
	logic [dtm_pkg::FIFO_AW-1:0]       wr_ptr_q;
	logic [dtm_pkg::FIFO_AW-1:0]       rd_ptr_q;
	logic [dtm_pkg::FIFO_CW-1:0]       count_q;
	logic                              do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + dtm_pkg::FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + dtm_pkg::FIFO_AW'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + dtm_pkg::FIFO_CW'(1);
				2'b01:   count_q <= count_q - dtm_pkg::FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/dfa_table_matcher.sv */
// dfa_table_matcher: top level of the table-driven dfa recognizer and greedy matcher
//
//  channel   direction  beat
//  in_ch     sink       table write, accept-flag write, character or end of string
//  out_ch    source     accepted flag and match length, at most one per string
//  cfg       write only match_mode, one bit
//
//  one beat per cycle while in_ch.ready is high; a result passes s1, s2 and the output queue
//  the loop is table read -> next state -> next table read address
//  after reset a clearing sweep of all 32768 entries empties the table, in_ch.ready low
//  in_ch.ready drops during that sweep and when the four-entry output queue could overflow

`default_nettype none

module dfa_table_matcher (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dtm_in_if.sink     in_ch,
	dtm_out_if.source  out_ch,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata
);

	logic                          match_mode_q;
	logic                          fire;
	logic                          busy;
	logic                          vld_s1;
	dtm_pkg::dtm_item_t            item;
	dtm_pkg::dtm_step_t            step_s2;
	logic                          res_valid;
	dtm_pkg::dtm_res_t             res;
	dtm_pkg::dtm_res_t             head;
	logic [dtm_pkg::FIFO_CW-1:0]   fifo_cnt;
	logic [dtm_pkg::FIFO_CW-1:0]   pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_mode_q <= 1'b0;
		end else if (cfg_we) begin
			match_mode_q <= cfg_wdata;
		end
	end

	// every beat in flight reserves a queue slot
	assign pending = fifo_cnt + dtm_pkg::FIFO_CW'(vld_s1) + dtm_pkg::FIFO_CW'(step_s2.vld);
	assign in_ch.ready = !busy && (pending < dtm_pkg::FIFO_CW'(dtm_pkg::FIFO_DEPTH));
	assign fire = in_ch.valid && in_ch.ready;

	assign item = '{
		mode:        in_ch.mode,
		state_index: in_ch.state_index,
		character:   in_ch.character,
		next_state:  in_ch.next_state,
		entry_valid: in_ch.entry_valid,
		accept_flag: in_ch.accept_flag
	};

	dtm_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item),
		.busy    (busy),
		.vld_s1  (vld_s1),
		.step_s2 (step_s2)
	);

	dtm_verdict u_verdict (
		.clk        (clk),
		.arst_n     (arst_n),
		.match_mode (match_mode_q),
		.step       (step_s2),
		.res_valid  (res_valid),
		.res        (res)
	);

	dtm_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (out_ch.ready),
		.not_empty (out_ch.valid),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign out_ch.accepted     = head.accepted;
	assign out_ch.match_length = head.match_length;

endmodule

`default_nettype wire

/* rtl/dtm_checker.sv */
// dtm_checker: port-level assertions of the matcher and their bind
`default_nettype none

module dtm_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [1:0]                    in_mode,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic                          out_accepted,
	input  wire logic [dtm_pkg::LEN_BITS-1:0]  out_match_length
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_accepted)
			&& $stable(out_match_length))
		else $error("result changed while stalled");

	// a failed match never carries a length
	a_fail_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_accepted |-> out_match_length == '0)
		else $error("failed match with nonzero length");

	// table is being cleared right after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !in_ready)
		else $error("input taken during clearing sweep");

	// a fresh result comes from an earlier character or end beat
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3)
			&& ($past(in_mode, 3) == dtm_pkg::MODE_CHAR
			|| $past(in_mode, 3) == dtm_pkg::MODE_END))
		else $error("result without a matching beat");

endmodule

bind dfa_table_matcher dtm_checker u_dtm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_mode          (in_ch.mode),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_accepted     (out_ch.accepted),
	.out_match_length (out_ch.match_length)
);

`default_nettype wire

/* sim/dtm_checker.sv */
// dtm_scoreboard: watches the matcher channels, predicts each verdict beat and compares it
`timescale 1ns / 100ps

module dtm_scoreboard (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dtm_in_if          in_ch,
	dtm_out_if         out_ch,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	output int         errors,
	output int         pending,
	output int         checked
);

	logic [dtm_pkg::TBL_W-1:0]      trans_tbl [dtm_pkg::TBL_DEPTH];
	logic                           accepting [dtm_pkg::STATE_COUNT];
	logic [dtm_pkg::STATE_BITS-1:0] cur_state;
	logic [dtm_pkg::LEN_BITS-1:0]   seen_len;
	logic                           reached;
	logic                           decided;
	logic                           greedy;
	dtm_pkg::dtm_res_t              verdict_q [$];
	dtm_pkg::dtm_res_t              want;
	dtm_pkg::dtm_res_t              got_res;
	dtm_pkg::dtm_item_t             beat;
	int                             err_cnt;
	int                             chk_cnt;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("mismatch in %s: got %0d, predicted %0d at %0t", what, got, exp_val, $time);
		err_cnt++;
	endtask

	function automatic logic dfa_advance(input dtm_pkg::dtm_item_t it,
			output dtm_pkg::dtm_res_t res);
		logic [dtm_pkg::TBL_W-1:0]    ent;
		logic [dtm_pkg::LEN_BITS-1:0] prior;
		logic                         emits;
		res   = '0;
		emits = 1'b0;
		case (dtm_pkg::dtm_mode_t'(it.mode))
			dtm_pkg::MODE_WR_TRANS: begin
				trans_tbl[{it.state_index, it.character}] =
					it.entry_valid ? {1'b1, it.next_state} : '0;
			end
			dtm_pkg::MODE_WR_ACC: begin
				accepting[it.state_index] = it.accept_flag;
			end
			dtm_pkg::MODE_CHAR: begin
				if (!decided) begin
					ent = trans_tbl[{cur_state, it.character}];
					if (!ent[dtm_pkg::TBL_W-1]) begin
						decided = 1'b1;
						emits   = 1'b1;
					end else begin
						prior     = seen_len;
						cur_state = ent[dtm_pkg::STATE_BITS-1:0];
						if (seen_len != '1) begin
							seen_len = seen_len + dtm_pkg::LEN_BITS'(1);
						end
						if (greedy) begin
							if (accepting[cur_state]) begin
								reached = 1'b1;
							end else if (reached) begin
								decided          = 1'b1;
								res.accepted     = 1'b1;
								res.match_length = prior;
								emits            = 1'b1;
							end
						end
					end
				end
			end
			default: begin
				if (!decided) begin
					emits = 1'b1;
					if (!greedy) begin
						res.accepted = accepting[cur_state];
					end else if (reached) begin
						res.accepted     = 1'b1;
						res.match_length = seen_len;
					end
				end
				cur_state = '0;
				seen_len  = '0;
				reached   = 1'b0;
				decided   = 1'b0;
			end
		endcase
		return emits;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_tbl = '{default: '0};
			accepting = '{default: 1'b0};
			cur_state = '0;
			seen_len  = '0;
			reached   = 1'b0;
			decided   = 1'b0;
			greedy    = 1'b0;
			verdict_q.delete();
			err_cnt   = 0;
			chk_cnt   = 0;
			errors  <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result beat with nothing pending", out_ch.accepted, -1);
				end else begin
					want = verdict_q.pop_front();
					if (out_ch.accepted !== want.accepted) begin
						report_mismatch("accepted", out_ch.accepted, want.accepted);
					end
					if (out_ch.match_length !== want.match_length) begin
						report_mismatch("match_length", out_ch.match_length, want.match_length);
					end
					chk_cnt++;
				end
			end
			if (cfg_we) begin
				greedy = cfg_wdata;
			end
			if (in_ch.valid && in_ch.ready) begin
				beat.mode        = in_ch.mode;
				beat.state_index = in_ch.state_index;
				beat.character   = in_ch.character;
				beat.next_state  = in_ch.next_state;
				beat.entry_valid = in_ch.entry_valid;
				beat.accept_flag = in_ch.accept_flag;
				if (dfa_advance(beat, got_res)) begin
					verdict_q.push_back(got_res);
				end
			end
			errors  <= err_cnt;
			pending <= verdict_q.size();
			checked <= chk_cnt;
		end
	end

endmodule

/* sim/tb.sv */
// tb: stimulus, handshake pacing and verdict for the table-driven dfa matcher
`timescale 1ns / 100ps

module tb;

	localparam int QUIET_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   errors;
	int   pending;
	int   checked;

	dtm_in_if  in_ch ();
	dtm_out_if out_ch ();

	dfa_table_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	dtm_scoreboard u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	bit                             fast;
	int                             beats_sent;
	int                             strings_sent;
	int                             mode_writes;
	int                             quiet;
	int                             out_stall;
	int                             phase;
	int                             nst;
	int                             nch;
	int                             len;
	int                             pick;
	int                             phase_start;
	int                             rand_start;
	logic [dtm_pkg::STATE_BITS-1:0] sid [6];
	logic [dtm_pkg::CHAR_BITS-1:0]  alpha [4];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic dtm_pkg::dtm_item_t rand_beat();
		logic [31:0] r;
		r = $urandom;
		return dtm_pkg::dtm_item_t'(r[$bits(dtm_pkg::dtm_item_t)-1:0]);
	endfunction

	function automatic logic [dtm_pkg::STATE_BITS-1:0] pick_state(input int n);
		return sid[3'($urandom_range(0, n - 1))];
	endfunction

	function automatic logic [dtm_pkg::CHAR_BITS-1:0] pick_char(input int n);
		return alpha[2'($urandom_range(0, n - 1))];
	endfunction

	task automatic send_beat(input dtm_pkg::dtm_item_t it);
		int gap;
		gap = fast ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.mode        <= it.mode;
		in_ch.state_index <= it.state_index;
		in_ch.character   <= it.character;
		in_ch.next_state  <= it.next_state;
		in_ch.entry_valid <= it.entry_valid;
		in_ch.accept_flag <= it.accept_flag;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
	endtask

	task automatic put_trans(input logic [dtm_pkg::STATE_BITS-1:0] st,
			input logic [dtm_pkg::CHAR_BITS-1:0] ch,
			input logic [dtm_pkg::STATE_BITS-1:0] nx, input logic ev);
		dtm_pkg::dtm_item_t it;
		it             = rand_beat();
		it.mode        = dtm_pkg::MODE_WR_TRANS;
		it.state_index = st;
		it.character   = ch;
		it.next_state  = nx;
		it.entry_valid = ev;
		send_beat(it);
	endtask

	task automatic put_acc(input logic [dtm_pkg::STATE_BITS-1:0] st, input logic af);
		dtm_pkg::dtm_item_t it;
		it             = rand_beat();
		it.mode        = dtm_pkg::MODE_WR_ACC;
		it.state_index = st;
		it.accept_flag = af;
		send_beat(it);
	endtask

	task automatic put_char(input logic [dtm_pkg::CHAR_BITS-1:0] ch);
		dtm_pkg::dtm_item_t it;
		it           = rand_beat();
		it.mode      = dtm_pkg::MODE_CHAR;
		it.character = ch;
		send_beat(it);
	endtask

	task automatic put_end();
		dtm_pkg::dtm_item_t it;
		it      = rand_beat();
		it.mode = dtm_pkg::MODE_END;
		send_beat(it);
		strings_sent++;
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_match_mode(input logic m);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mode_writes++;
	endtask

	// result side pacing
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			out_stall = fast ? 0 : $urandom_range(0, 10);
			if (out_stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (out_stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("dfa_table_matcher verification failed");
			$finish;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.mode        <= '0;
		in_ch.state_index <= '0;
		in_ch.character   <= '0;
		in_ch.next_state  <= '0;
		in_ch.entry_valid <= 1'b0;
		in_ch.accept_flag <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= 1'b0;
		fast         = 1'b0;
		beats_sent   = 0;
		strings_sent = 0;
		mode_writes  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// whole-string mode
		set_match_mode(1'b0);
		put_end();
		put_char(7'h7F);
		put_char(7'h00);
		put_end();
		put_acc(8'h00, 1'b1);
		put_end();
		put_trans(8'h00, 7'h7F, 8'hFF, 1'b1);
		put_acc(8'hFF, 1'b1);
		put_acc(8'h00, 1'b0);
		put_char(7'h7F);
		put_end();
		put_trans(8'hFF, 7'h00, 8'h00, 1'b1);
		put_char(7'h7F);
		put_char(7'h00);
		put_end();
		put_trans(8'h00, 7'h7F, 8'hFF, 1'b0);
		put_char(7'h7F);
		put_end();
		put_trans(8'h00, 7'h7F, 8'hFF, 1'b1);

		// greedy mode
		set_match_mode(1'b1);
		put_end();
		put_char(7'h7F);
		put_char(7'h00);
		put_char(7'h7F);
		put_end();
		put_char(7'h7F);
		put_end();
		put_char(7'h7F);
		put_char(7'h05);
		put_end();

		rand_start = beats_sent;
		for (phase = 0; beats_sent - rand_start < 1800; phase++) begin
			fast = (phase % 4 == 3);
			set_match_mode((phase < 2) ? phase[0] : logic'($urandom_range(0, 1)));
			nst = $urandom_range(2, 6);
			nch = $urandom_range(2, 4);
			sid[0] = '0;
			for (int i = 1; i < nst; i++) begin
				sid[3'(i)] = dtm_pkg::STATE_BITS'($urandom_range(0, 255));
			end
			for (int j = 0; j < nch; j++) begin
				alpha[2'(j)] = dtm_pkg::CHAR_BITS'($urandom_range(0, 127));
			end
			for (int i = 0; i < nst; i++) begin
				for (int j = 0; j < nch; j++) begin
					put_trans(sid[3'(i)], alpha[2'(j)], pick_state(nst),
						$urandom_range(0, 15) != 0);
				end
			end
			for (int i = 0; i < nst; i++) begin
				put_acc(sid[3'(i)], logic'($urandom_range(0, 1)));
			end
			phase_start = beats_sent;
			while (beats_sent - phase_start < 200) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12);
				for (int k = 0; k < len; k++) begin
					pick = $urandom_range(0, 39);
					case (pick)
						0: put_char(dtm_pkg::CHAR_BITS'($urandom_range(0, 127)));
						1: put_trans(pick_state(nst), pick_char(nch), pick_state(nst), 1'b1);
						2: put_acc(pick_state(nst), logic'($urandom_range(0, 1)));
						3: set_match_mode(logic'($urandom_range(0, 1)));
						4: drain_results();
						default: put_char(pick_char(nch));
					endcase
				end
				put_end();
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("run covered %0d input beats in %0d strings over %0d table phases",
			beats_sent, strings_sent, phase);
		$display("%0d verdicts checked in both match modes, %0d mode writes, missing transitions",
			checked, mode_writes);
		if (errors == 0 && pending == 0) begin
			$display("dfa_table_matcher verification clean");
		end else begin
			$display("dfa_table_matcher verification failed");
		end
		$finish;
	end

endmodule
